FILE: rtl/core/sepq_pkg.sv
// Shared types, constants and helpers for the stereo peaking EQ biquad core.
`default_nettype none

package sepq_pkg;

    // Sample and coefficient formats
    localparam int SAMPLE_BITS = 24;               // Q1.23 samples
    localparam int COEF_BITS   = 32;               // Q6.26 coefficients
    localparam int FRAC_BITS   = 26;
    localparam int NUM_COEFS   = 5;
    localparam int REG_IDX_W   = 3;

    // Warm-up crossfade; length must be a power of two (division is a shift)
    localparam int WARMUP_FRAMES = 1024;
    localparam int CNT_W         = $clog2(WARMUP_FRAMES + 1);
    localparam int FADE_SH       = $clog2(WARMUP_FRAMES);
    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(WARMUP_FRAMES);
    localparam logic [FADE_SH-1:0] FADE_HALF = FADE_SH'(WARMUP_FRAMES / 2);

    // Digit-serial multiplier geometry
    localparam int DIG_W  = 4;
    localparam int S_DIG  = SAMPLE_BITS / DIG_W;          // digits of a sample
    localparam int C_DIG  = (CNT_W + DIG_W) / DIG_W;      // digits of the count, sign bit zero
    localparam int DIDX_W = $clog2(S_DIG);
    localparam logic [DIDX_W-1:0] S_LAST = DIDX_W'(S_DIG - 1);
    localparam logic [DIDX_W-1:0] C_LAST = DIDX_W'(C_DIG - 1);
    localparam int OPA_W  = COEF_BITS + 1;                // room for a negated coefficient
    localparam int PROD_W = OPA_W + DIG_W + 1;
    localparam int ACC_W  = COEF_BITS + SAMPLE_BITS + 4;  // five products, no overflow

    // Rounding / saturation
    localparam int SAT_IN_W = ACC_W - FRAC_BITS + 1;
    localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);

    // Register indexes; also used as the product index of the MAC sequence
    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic signed [COEF_BITS-1:0] COEF_B0_RESET = 32'sd67108864;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } sepq_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } sepq_out_t;

    typedef struct packed {
        logic              load;     // capture operands
        logic              clr;      // clear accumulator on load
        logic              step;     // one digit product
        logic              last;     // top digit, taken as signed
        logic [DIDX_W-1:0] dig_idx;
    } sepq_mac_ctl_t;

    typedef struct packed {
        logic                 in_ready;
        sepq_mac_ctl_t        mac;
        logic [REG_IDX_W-1:0] prod_idx;
        logic                 ch;
        logic                 fade_op;
        logic                 round_en;
        logic                 fround_en;
        logic                 out_en;
    } sepq_seq_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAMPLE_BITS'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r = SAMPLE_BITS'(SAT_LO);
        end
        else
        begin
            r = SAMPLE_BITS'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sepq_mac.sv
// Digit-serial multiply-accumulate: coefficient times sample, 4 bits per cycle.
`default_nettype none

module sepq_mac
    import sepq_pkg::*;
(
    input  wire logic                    clk,
    input  wire sepq_mac_ctl_t           ctl,
    input  wire logic signed [OPA_W-1:0] opa,
    input  wire logic [SAMPLE_BITS-1:0]  opb,
    output logic signed [ACC_W-1:0]      acc
);

    logic signed [OPA_W-1:0]   a_reg;
    logic [SAMPLE_BITS-1:0]    b_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DIG_W:0]     digit;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   part;

    // low digit of the shift register; top digit carries the sign
    assign digit = ctl.last ? $signed({b_reg[DIG_W-1], b_reg[DIG_W-1:0]})
                            : $signed({1'b0, b_reg[DIG_W-1:0]});
    // both operands widened to the product width before the multiply
    assign prod  = PROD_W'(a_reg) * PROD_W'(digit);
    assign part  = ACC_W'(prod) <<< (ctl.dig_idx * DIG_W);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg <= opa;
            b_reg <= opb;
            if (ctl.clr)
            begin
                acc_reg <= '0;
            end
        end
        else if (ctl.step)
        begin
            acc_reg <= acc_reg + part;
            b_reg   <= b_reg >> DIG_W;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sepq_seq.sv
// Frame sequencer: walks products, rounding and crossfade for both channels.
`default_nettype none

module sepq_seq
    import sepq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic fade,
    input  wire logic out_free,
    output sepq_seq_t ctl
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_STEP   = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_FLOAD  = 3'd4;
    localparam logic [2:0] ST_FSTEP  = 3'd5;
    localparam logic [2:0] ST_FROUND = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic                 ch_reg, ch_next;
    logic [REG_IDX_W-1:0] prod_reg, prod_next;
    logic [DIDX_W-1:0]    dig_reg, dig_next;

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        prod_next       = prod_reg;
        dig_next        = dig_reg;
        ctl             = '0;
        ctl.ch          = ch_reg;
        ctl.prod_idx    = prod_reg;
        ctl.mac.dig_idx = dig_reg;

        case (state_reg)
            ST_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (in_valid)
                begin
                    ch_next    = 1'b0;
                    prod_next  = REG_B0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ctl.mac.load = 1'b1;
                ctl.mac.clr  = (prod_reg == REG_B0);
                dig_next     = '0;
                state_next   = ST_STEP;
            end
            ST_STEP:
            begin
                ctl.mac.step = 1'b1;
                ctl.mac.last = (dig_reg == S_LAST);
                if (dig_reg == S_LAST)
                begin
                    if (prod_reg == REG_A2)
                    begin
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        prod_next  = prod_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    dig_next = dig_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                ctl.round_en = 1'b1;
                if (fade)
                begin
                    state_next = ST_FLOAD;
                end
                else if (!ch_reg)
                begin
                    ch_next    = 1'b1;
                    prod_next  = REG_B0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_FLOAD:
            begin
                ctl.mac.load = 1'b1;
                ctl.mac.clr  = 1'b1;
                ctl.fade_op  = 1'b1;
                dig_next     = '0;
                state_next   = ST_FSTEP;
            end
            ST_FSTEP:
            begin
                ctl.mac.step = 1'b1;
                ctl.fade_op  = 1'b1;
                ctl.mac.last = (dig_reg == C_LAST);
                if (dig_reg == C_LAST)
                begin
                    state_next = ST_FROUND;
                end
                else
                begin
                    dig_next = dig_reg + 1'b1;
                end
            end
            ST_FROUND:
            begin
                ctl.fround_en = 1'b1;
                if (!ch_reg)
                begin
                    ch_next    = 1'b1;
                    prod_next  = REG_B0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ctl.out_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
            prod_reg  <= REG_B0;
            dig_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            prod_reg  <= prod_next;
            dig_reg   <= dig_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/stereo_peaking_eq_biquad_core.sv
// Top level of the stereo peaking EQ biquad core (direct form I, warm-up crossfade).
`default_nettype none

// Stereo direct-form-I biquad. Each input transfer carries one left/right frame
// of signed Q1.23 samples; each output transfer carries the filtered frame,
// rounded half-up and saturated to 24 bits. Five Q6.26 coefficients (b0, b1,
// b2, a1, a2; a1/a2 are subtracted) are written through cfg_we/cfg_idx/cfg_data;
// the user must write them only while the core is idle (the core does not
// enforce this); indexes past a2 are ignored. After reset the first 1024 frames
// fade linearly from the dry input to the filtered output (first frame fully
// dry, ties rounded away from zero); history always keeps the filtered sample.
// All products go through one 33x5-bit digit-serial multiplier that consumes
// 4 bits of the sample operand per cycle. A frame occupies the core from the
// cycle of its input transfer through the cycle that loads the output register:
// the transfer, per channel five products of one load and the digit steps of
// the sample, then a rounding step, plus a crossfade load, digit steps and
// rounding per channel while warming, and the output cycle. The output cycle
// waits as long as the previous result is still held in the output register.
// A new frame is taken as soon as the previous result sits in the output register.
module stereo_peaking_eq_biquad_core
    import sepq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sepq_in_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sepq_out_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_idx,
    input  wire logic [COEF_BITS-1:0] cfg_data
);

    sepq_seq_t ctl;

    // coefficient file
    logic signed [COEF_BITS-1:0]   coef_reg [NUM_COEFS];

    // frame under work and per-channel history (index = channel)
    sepq_in_t                      in_reg;
    logic signed [SAMPLE_BITS-1:0] x1_reg [2];
    logic signed [SAMPLE_BITS-1:0] x2_reg [2];
    logic signed [SAMPLE_BITS-1:0] y1_reg [2];
    logic signed [SAMPLE_BITS-1:0] y2_reg [2];
    logic signed [SAMPLE_BITS-1:0] res_reg [2];

    // warm-up state
    logic [CNT_W-1:0]              cnt_reg;
    logic                          warming_reg;

    // output register
    logic                          out_valid_reg;
    sepq_out_t                     out_data_reg;
    logic                          out_free;

    // datapath
    logic signed [OPA_W-1:0]       opa;
    logic [SAMPLE_BITS-1:0]        opb;
    logic signed [ACC_W-1:0]       acc;
    logic signed [SAMPLE_BITS-1:0] x_ch;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [SAT_IN_W-2:0]    ysh;
    logic signed [SAT_IN_W-1:0]    yrnd;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAT_IN_W-2:0]    qb;
    logic [FADE_SH-1:0]            qlow;
    logic                          qinc;
    logic signed [SAT_IN_W-1:0]    osum;
    logic signed [SAMPLE_BITS-1:0] o;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = ctl.in_ready;
    assign x_ch     = ctl.ch ? in_reg.right_in : in_reg.left_in;

    sepq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .fade     (warming_reg),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // Operand select. Feedback taps are negated here so the MAC only adds.
    // The crossfade product is (y - x) * count, y taken from fresh history.
    always_comb
    begin
        diff = (SAMPLE_BITS + 1)'(y1_reg[ctl.ch]) - (SAMPLE_BITS + 1)'(x_ch);
        opa  = '0;
        opb  = '0;
        if (ctl.fade_op)
        begin
            opa = OPA_W'(diff);
            opb = SAMPLE_BITS'(cnt_reg);
        end
        else
        begin
            case (ctl.prod_idx)
                REG_B0:
                begin
                    opa = OPA_W'(coef_reg[REG_B0]);
                    opb = x_ch;
                end
                REG_B1:
                begin
                    opa = OPA_W'(coef_reg[REG_B1]);
                    opb = x1_reg[ctl.ch];
                end
                REG_B2:
                begin
                    opa = OPA_W'(coef_reg[REG_B2]);
                    opb = x2_reg[ctl.ch];
                end
                REG_A1:
                begin
                    opa = -(OPA_W'(coef_reg[REG_A1]));
                    opb = y1_reg[ctl.ch];
                end
                REG_A2:
                begin
                    opa = -(OPA_W'(coef_reg[REG_A2]));
                    opb = y2_reg[ctl.ch];
                end
                default:
                begin
                    opa = '0;
                    opb = '0;
                end
            endcase
        end
    end

    sepq_mac u_mac (
        .clk (clk),
        .ctl (ctl.mac),
        .opa (opa),
        .opb (opb),
        .acc (acc)
    );

    // Round half up: floor(acc / 2^26) plus the bit just below the cut.
    assign ysh  = acc[ACC_W-1:FRAC_BITS];
    assign yrnd = SAT_IN_W'(ysh) + SAT_IN_W'(acc[FRAC_BITS-1]);
    assign y    = sat_sample(yrnd);

    // Crossfade: divide by the fade length, ties away from zero.
    // Negative sums round up only strictly above the half point.
    assign qb   = acc[FADE_SH+SAT_IN_W-2:FADE_SH];
    assign qlow = acc[FADE_SH-1:0];
    assign qinc = acc[ACC_W-1] ? (qlow > FADE_HALF) : (qlow >= FADE_HALF);
    assign osum = SAT_IN_W'(qb) + SAT_IN_W'(qinc) + SAT_IN_W'(x_ch);
    assign o    = sat_sample(osum);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[REG_B0] <= COEF_B0_RESET;
            coef_reg[REG_B1] <= '0;
            coef_reg[REG_B2] <= '0;
            coef_reg[REG_A1] <= '0;
            coef_reg[REG_A2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_B0:  coef_reg[REG_B0] <= cfg_data;
                REG_B1:  coef_reg[REG_B1] <= cfg_data;
                REG_B2:  coef_reg[REG_B2] <= cfg_data;
                REG_A1:  coef_reg[REG_A1] <= cfg_data;
                REG_A2:  coef_reg[REG_A2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // input frame capture
    always_ff @(posedge clk)
    begin
        if (in_valid && ctl.in_ready)
        begin
            in_reg <= in_data;
        end
    end

    // filter history, updated once per channel when its sum is rounded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '{default: '0};
            x2_reg <= '{default: '0};
            y1_reg <= '{default: '0};
            y2_reg <= '{default: '0};
        end
        else if (ctl.round_en)
        begin
            x2_reg[ctl.ch] <= x1_reg[ctl.ch];
            x1_reg[ctl.ch] <= x_ch;
            y2_reg[ctl.ch] <= y1_reg[ctl.ch];
            y1_reg[ctl.ch] <= y;
        end
    end

    // per-channel results awaiting the output register
    always_ff @(posedge clk)
    begin
        if (ctl.round_en && !warming_reg)
        begin
            res_reg[ctl.ch] <= y;
        end
        else if (ctl.fround_en)
        begin
            res_reg[ctl.ch] <= o;
        end
    end

    // warm-up counter, advanced as each frame leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            warming_reg <= 1'b1;
        end
        else if (ctl.out_en && warming_reg)
        begin
            if (cnt_reg < CNT_MAX)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cnt_reg + CNT_W'(1) >= CNT_MAX)
            begin
                warming_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_en)
        begin
            out_data_reg.left_out  <= res_reg[0];
            out_data_reg.right_out <= res_reg[1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // once warm-up ends the count rests at the fade length
    a_warm_done: assert property (@(posedge clk) disable iff (!rst_n)
        !warming_reg |-> (cnt_reg == CNT_MAX))
        else $error("warm-up ended with count short of fade length");

    // one frame at a time: after an input transfer the core is busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a frame is in progress");

    // a result is never loaded over one still waiting
    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_en |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // crossfade pass only runs during warm-up
    a_fade_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fround_en || ctl.fade_op) |-> warming_reg)
        else $error("crossfade pass outside warm-up");

endmodule

`default_nettype wire
